@@ rtl/sph_pkg.sv @@
package sph_pkg;

  localparam int unsigned RowBits   = 7;
  localparam int unsigned ColBits   = 9;
  localparam int unsigned SlotBits  = 5;
  localparam int unsigned FillBits  = 6;
  localparam int unsigned CountBits = 32;
  localparam int unsigned AddrBits  = RowBits + ColBits;
  localparam int unsigned RingAddrBits = SlotBits + ColBits;
  localparam int unsigned RowsMax   = 128;
  localparam int unsigned ColsMax   = 512;
  localparam int unsigned WinMax    = 32;

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [1:0] MODE_CUM  = 2'd1;
  localparam logic [1:0] MODE_ROLL = 2'd2;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_PMIN  = 3'd1;
  localparam logic [2:0] REG_SCALE = 3'd2;
  localparam logic [2:0] REG_ROWS  = 3'd3;
  localparam logic [2:0] REG_COLS  = 3'd4;
  localparam logic [2:0] REG_WIN   = 3'd5;

  typedef enum logic [1:0] {
    K_NONE,
    K_SAMPLE,
    K_READ,
    K_CLEAR
  } kind_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] pmin;
    logic [15:0]        scale;
    logic [7:0]         rows;
    logic [9:0]         cols;
    logic [5:0]         win;
  } cfg_t;

  typedef struct packed {
    kind_e                 kind;
    logic                  rolling;
    logic                  add;
    logic                  remove;
    logic [RowBits-1:0]    row;
    logic [ColBits-1:0]    col;
    logic [SlotBits-1:0]   slot;
    logic [AddrBits-1:0]   raddr;
    logic                  read_ok;
    logic [FillBits-1:0]   fill;
    logic [CountBits-1:0]  total;
    logic                  len_err;
  } op_t;

endpackage

@@ rtl/spectrum_persistence_histogram_top.sv @@
// The back-end sequencer takes one queued beat at a time and finishes it before the next,
// doing single-port read-modify-writes on the density store and row ring.
// A clear request or any register write runs a clearing pass over all 65536 store
// entries, one entry per cycle, while no beat is accepted.
// Reset (rst_ni low, async) restores the register defaults and starts the same pass.
module spectrum_persistence_histogram_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] power_i,
  input  logic        sample_valid_i,
  input  logic        last_column_i,
  input  logic [6:0]  read_row_i,
  input  logic [8:0]  read_column_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] cell_count_o,
  output logic [6:0]  row_index_o,
  output logic        row_valid_o,
  output logic [5:0]  frames_in_window_o,
  output logic [31:0] frames_processed_o,
  output logic        frame_length_error_o
);
  import sph_pkg::*;

  cfg_t       cfg_q;
  logic       wr, cfg_wr, block, full, empty, push, pop;
  logic [2:0] idx;
  op_t        f_op, q_op;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign cfg_wr = wr && (idx == REG_MODE || idx == REG_PMIN || idx == REG_SCALE ||
                         idx == REG_ROWS || idx == REG_COLS || idx == REG_WIN);

  always_comb begin
    case (idx)
      REG_MODE:  prdata = {30'd0, cfg_q.mode};
      REG_PMIN:  prdata = {16'd0, cfg_q.pmin};
      REG_SCALE: prdata = {16'd0, cfg_q.scale};
      REG_ROWS:  prdata = {24'd0, cfg_q.rows};
      REG_COLS:  prdata = {22'd0, cfg_q.cols};
      REG_WIN:   prdata = {26'd0, cfg_q.win};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode  <= 2'd0;
      cfg_q.pmin  <= -16'sd30720;
      cfg_q.scale <= 16'd273;
      cfg_q.rows  <= 8'd128;
      cfg_q.cols  <= 10'd512;
      cfg_q.win   <= 6'd32;
    end else if (wr) begin
      case (idx)
        REG_MODE:  cfg_q.mode  <= pwdata[1:0];
        REG_PMIN:  cfg_q.pmin  <= pwdata[15:0];
        REG_SCALE: cfg_q.scale <= pwdata[15:0];
        REG_ROWS:  cfg_q.rows  <= pwdata[7:0];
        REG_COLS:  cfg_q.cols  <= pwdata[9:0];
        REG_WIN:   cfg_q.win   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  sph_front u_front (
    .clk_i, .rst_ni,
    .cfg_i(cfg_q), .cfg_wr_i(cfg_wr), .block_i(block),
    .in_valid_i, .in_ready_o,
    .req_type_i, .power_i, .sample_valid_i, .last_column_i, .read_row_i, .read_column_i,
    .full_i(full), .push_o(push), .op_o(f_op)
  );

  sph_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .op_i(f_op), .full_o(full),
    .pop_i(pop), .empty_o(empty), .op_o(q_op)
  );

  sph_back u_back (
    .clk_i, .rst_ni,
    .cfg_wr_i(cfg_wr), .block_o(block),
    .empty_i(empty), .op_i(q_op), .pop_o(pop),
    .out_valid_o, .out_ready_i,
    .cell_count_o, .row_index_o, .row_valid_o,
    .frames_in_window_o, .frames_processed_o, .frame_length_error_o
  );

endmodule

@@ rtl/sph_fifo.sv @@
module sph_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sph_pkg::op_t  op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output sph_pkg::op_t  op_o
);
  import sph_pkg::*;

  op_t        mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign op_o    = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

@@ rtl/sph_front.sv @@
module sph_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sph_pkg::cfg_t cfg_i,
  input  logic          cfg_wr_i,
  input  logic          block_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    req_type_i,
  input  logic [15:0]   power_i,
  input  logic          sample_valid_i,
  input  logic          last_column_i,
  input  logic [6:0]    read_row_i,
  input  logic [8:0]    read_column_i,
  input  logic          full_i,
  output logic          push_o,
  output sph_pkg::op_t  op_o
);
  import sph_pkg::*;

  logic [ColBits-1:0]   colpos_q, colpos_d;
  logic [SlotBits-1:0]  slot_q, slot_d;
  logic [FillBits-1:0]  fill_q, fill_d;
  logic [CountBits-1:0] total_q, total_d;

  logic                s1_v_q;
  op_t                 s1_op_q, op_d;
  logic signed [33:0]  prod_q, prod_d;

  logic [7:0]  rows_c;
  logic [9:0]  cols_c;
  logic [5:0]  win_c;
  logic        enabled, sample, is_last, accept;
  logic [ColBits-1:0]  col;
  logic [SlotBits-1:0] slot;
  logic [5:0]          slot_inc;
  logic signed [16:0]  diff;
  logic [17:0]         rq;
  logic [7:0]          rows_m1;

  always_comb begin
    rows_c = (cfg_i.rows == 8'd0) ? 8'd1 : (cfg_i.rows > 8'(RowsMax)) ? 8'(RowsMax) : cfg_i.rows;
    cols_c = (cfg_i.cols == 10'd0) ? 10'd1 :
             (cfg_i.cols > 10'(ColsMax)) ? 10'(ColsMax) : cfg_i.cols;
    win_c  = (cfg_i.win == 6'd0) ? 6'd1 : (cfg_i.win > 6'(WinMax)) ? 6'(WinMax) : cfg_i.win;
  end

  assign push_o     = s1_v_q && !full_i;
  assign in_ready_o = !block_i && (!s1_v_q || !full_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    enabled  = cfg_i.mode == MODE_CUM || cfg_i.mode == MODE_ROLL;
    sample   = req_type_i == REQ_SAMPLE && enabled;
    col      = ({1'b0, colpos_q} >= cols_c) ? ColBits'(cols_c - 10'd1) : colpos_q;
    is_last  = {1'b0, col} == cols_c - 10'd1;
    slot     = ({1'b0, slot_q} < win_c) ? slot_q : '0;
    slot_inc = {1'b0, slot} + 6'd1;
    diff     = $signed({power_i[15], power_i}) - $signed({cfg_i.pmin[15], cfg_i.pmin});
    prod_d   = diff * $signed({1'b0, cfg_i.scale});

    colpos_d = colpos_q;
    slot_d   = slot_q;
    fill_d   = fill_q;
    total_d  = total_q;
    if (sample) begin
      if (is_last) begin
        colpos_d = '0;
        if (cfg_i.mode == MODE_ROLL) begin
          slot_d = (slot_inc == win_c) ? '0 : slot_inc[SlotBits-1:0];
          if (fill_q < win_c) fill_d = fill_q + 6'd1;
        end
        if (total_q != '1) total_d = total_q + 1'b1;
      end else begin
        colpos_d = col + 1'b1;
      end
    end else if (req_type_i == REQ_CLEAR) begin
      colpos_d = '0;
      slot_d   = '0;
      fill_d   = '0;
      total_d  = '0;
    end

    op_d         = '0;
    op_d.rolling = cfg_i.mode == MODE_ROLL;
    op_d.col     = col;
    op_d.slot    = slot;
    op_d.remove  = fill_q >= win_c;
    op_d.raddr   = {read_row_i, read_column_i};
    op_d.read_ok = {1'b0, read_row_i} < rows_c && {1'b0, read_column_i} < cols_c;
    op_d.fill    = fill_d;
    op_d.total   = total_d;
    case (req_type_i)
      REQ_SAMPLE: begin
        if (enabled) begin
          op_d.kind    = K_SAMPLE;
          op_d.add     = sample_valid_i;
          op_d.len_err = last_column_i != is_last;
        end else begin
          op_d.kind = K_NONE;
        end
      end
      REQ_READ:  op_d.kind = K_READ;
      REQ_CLEAR: op_d.kind = K_CLEAR;
      default:   op_d.kind = K_NONE;
    endcase
  end

  // row quantize from the registered product
  always_comb begin
    rows_m1 = rows_c - 8'd1;
    rq      = prod_q[33:16];
    op_o    = s1_op_q;
    if (!s1_op_q.add || prod_q <= 0) op_o.row = '0;
    else if (rq > {10'd0, rows_m1}) op_o.row = rows_m1[RowBits-1:0];
    else op_o.row = rq[RowBits-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q <= op_d;
      prod_q  <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      colpos_q <= '0;
      slot_q   <= '0;
      fill_q   <= '0;
      total_q  <= '0;
    end else if (cfg_wr_i) begin
      s1_v_q   <= 1'b0;
      colpos_q <= '0;
      slot_q   <= '0;
      fill_q   <= '0;
      total_q  <= '0;
    end else begin
      if (accept) s1_v_q <= 1'b1;
      else if (push_o) s1_v_q <= 1'b0;
      if (accept) begin
        colpos_q <= colpos_d;
        slot_q   <= slot_d;
        fill_q   <= fill_d;
        total_q  <= total_d;
      end
    end
  end

endmodule

@@ rtl/sph_back.sv @@
module sph_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_wr_i,
  output logic          block_o,
  input  logic          empty_i,
  input  sph_pkg::op_t  op_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [31:0]   cell_count_o,
  output logic [6:0]    row_index_o,
  output logic          row_valid_o,
  output logic [5:0]    frames_in_window_o,
  output logic [31:0]   frames_processed_o,
  output logic          frame_length_error_o
);
  import sph_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DISP  = 4'd1;
  localparam logic [3:0] ST_RING  = 4'd2;
  localparam logic [3:0] ST_DEC   = 4'd3;
  localparam logic [3:0] ST_RDNEW = 4'd4;
  localparam logic [3:0] ST_INC   = 4'd5;
  localparam logic [3:0] ST_RDOUT = 4'd6;
  localparam logic [3:0] ST_OUT   = 4'd7;
  localparam logic [3:0] ST_CLR   = 4'd8;

  logic [CountBits-1:0] store [2**AddrBits];
  logic [7:0]           ring  [2**RingAddrBits];

  logic [3:0]           state_q, state_d;
  op_t                  op_q;
  logic                 clr_pend_q, clr_pend_d, clr_res_q, clr_res_d;
  logic [AddrBits-1:0]  clr_addr_q, clr_addr_d;

  logic                 st_rd_en, st_we, ring_rd_en, ring_we;
  logic [AddrBits-1:0]  st_raddr, st_waddr;
  logic [CountBits-1:0] st_wdata, st_rdata_q;
  logic [7:0]           ring_rdata_q;
  logic [RingAddrBits-1:0] ring_addr;

  logic                 out_free, out_load;
  logic [CountBits-1:0] out_count;

  assign out_free  = !out_valid_o || out_ready_i;
  assign block_o   = clr_pend_q || state_q == ST_CLR;
  assign ring_addr = {op_q.slot, op_q.col};

  always_comb begin
    state_d    = state_q;
    clr_pend_d = clr_pend_q || cfg_wr_i;
    clr_res_d  = clr_res_q;
    clr_addr_d = clr_addr_q;
    pop_o      = 1'b0;
    st_rd_en   = 1'b0;
    st_raddr   = {op_q.row, op_q.col};
    st_we      = 1'b0;
    st_waddr   = {op_q.row, op_q.col};
    st_wdata   = '0;
    ring_rd_en = 1'b0;
    ring_we    = 1'b0;
    out_load   = 1'b0;
    out_count  = '0;
    case (state_q)
      ST_IDLE: begin
        if (clr_pend_q) begin
          clr_pend_d = cfg_wr_i;
          clr_res_d  = 1'b0;
          clr_addr_d = '0;
          state_d    = ST_CLR;
        end else if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        case (op_q.kind)
          K_SAMPLE: begin
            if (op_q.rolling) begin
              ring_rd_en = 1'b1;
              state_d    = ST_RING;
            end else if (op_q.add) begin
              st_rd_en = 1'b1;
              state_d  = ST_INC;
            end else begin
              state_d = ST_OUT;
            end
          end
          K_READ: begin
            st_raddr = op_q.raddr;
            if (op_q.read_ok) begin
              st_rd_en = 1'b1;
              state_d  = ST_RDOUT;
            end else begin
              state_d = ST_OUT;
            end
          end
          K_CLEAR: begin
            clr_res_d  = 1'b1;
            clr_addr_d = '0;
            state_d    = ST_CLR;
          end
          default: state_d = ST_OUT;
        endcase
      end
      ST_RING: begin
        ring_we  = 1'b1;
        // old row removed only once the window is full
        st_raddr = {ring_rdata_q[RowBits-1:0], op_q.col};
        if (op_q.remove && ring_rdata_q[7]) begin
          st_rd_en = 1'b1;
          state_d  = ST_DEC;
        end else if (op_q.add) begin
          st_rd_en = 1'b1;
          state_d  = ST_RDNEW;
          st_raddr = {op_q.row, op_q.col};
          state_d  = ST_INC;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DEC: begin
        st_we    = 1'b1;
        st_waddr = {ring_rdata_q[RowBits-1:0], op_q.col};
        st_wdata = (st_rdata_q != '0) ? st_rdata_q - 1'b1 : st_rdata_q;
        state_d  = op_q.add ? ST_RDNEW : ST_OUT;
      end
      ST_RDNEW: begin
        st_rd_en = 1'b1;
        state_d  = ST_INC;
      end
      ST_INC: begin
        if (out_free) begin
          st_we     = 1'b1;
          st_wdata  = (st_rdata_q != '1) ? st_rdata_q + 1'b1 : st_rdata_q;
          out_load  = 1'b1;
          out_count = st_wdata;
          state_d   = ST_IDLE;
        end
      end
      ST_RDOUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_count = st_rdata_q;
          state_d   = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_CLR: begin
        st_we      = 1'b1;
        st_waddr   = clr_addr_q;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == '1) state_d = clr_res_q ? ST_OUT : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_we) store[st_waddr] <= st_wdata;
    if (st_rd_en) st_rdata_q <= store[st_raddr];
    if (ring_we) ring[ring_addr] <= {op_q.add, op_q.row};
    if (ring_rd_en) ring_rdata_q <= ring[ring_addr];
    if (pop_o) op_q <= op_i;
    if (out_load) begin
      cell_count_o         <= out_count;
      row_index_o          <= op_q.row;
      row_valid_o          <= op_q.add;
      frames_in_window_o   <= op_q.fill;
      frames_processed_o   <= op_q.total;
      frame_length_error_o <= op_q.len_err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clr_pend_q  <= 1'b1;
      clr_res_q   <= 1'b0;
      clr_addr_q  <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_pend_q <= clr_pend_d;
      clr_res_q  <= clr_res_d;
      clr_addr_q <= clr_addr_d;
      if (out_load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  a_no_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_we && st_rd_en)) else $error("store read and write in one cycle");

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> !pop_o) else $error("queue popped during clear");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_o || out_ready_i)) else $error("result overwritten");

endmodule
